// ----- hdl/lbs_pkg.sv -----
// Shared types, sizes and helpers of the linear blend skinning engine.
// Used by every module in hdl; depends on nothing else.
package lbs_pkg;

	localparam int MaxBones   = 64;
	localparam int MaxWeights = 4;
	localparam int NumLanes   = (MaxWeights < 4) ? MaxWeights : 4;
	localparam int BoneW      = (MaxBones > 1) ? $clog2(MaxBones) : 1;
	localparam int PalDepth   = MaxBones * 16;
	localparam int NumElem    = 12;
	localparam int BoneIdW    = 6;
	localparam int WgtW       = 16;
	localparam int InDataW    = 328;
	localparam int OutDataW   = 192;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [47:0] prod_t;
	typedef logic signed [63:0] wide_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} lbs_adv_t;

	function automatic q16_t sat_q16(input wide_t v);
		q16_t r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = q16_t'(v);
		end
		return r;
	endfunction

endpackage

// ----- hdl/lbs_lane.sv -----
// One blend lane: a private copy of the bone palette and the weight products
// for one bone/weight pair. Depends on lbs_pkg.
module lbs_lane (
	input  logic                         clk,
	input  lbs_pkg::lbs_adv_t            adv,
	input  logic                         wr_en,
	input  logic [3:0]                   wr_elem,
	input  logic [lbs_pkg::BoneW-1:0]    wr_bone,
	input  lbs_pkg::q16_t                wr_data,
	input  logic [lbs_pkg::BoneIdW-1:0]  rd_bone,
	input  logic [lbs_pkg::WgtW-1:0]     weight,
	input  logic                         act,
	output lbs_pkg::prod_t               prod_s2 [lbs_pkg::NumElem]
);

	logic                        in_range;
	logic [lbs_pkg::BoneW-1:0]   rd_idx;
	logic [lbs_pkg::WgtW-1:0]    w_s1;
	logic                        use_s1;

	assign in_range = 32'(rd_bone) < lbs_pkg::MaxBones;
	assign rd_idx   = lbs_pkg::BoneW'(rd_bone);

	// An inactive or out-of-range pair gives a zero product, whatever its
	// palette banks return.
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			w_s1   <= (act && in_range) ? weight : '0;
			use_s1 <= act && in_range;
		end
	end

	// Each matrix element has its own bank so that all twelve read together.
	for (genvar e = 0; e < lbs_pkg::NumElem; e++) begin : g_elem
		lbs_pkg::q16_t mem [lbs_pkg::MaxBones];
		lbs_pkg::q16_t elem_s1;

		always_ff @(posedge clk) begin
			if (wr_en && wr_elem == 4'(e)) begin
				mem[wr_bone] <= wr_data;
			end
			if (adv.s1) begin
				elem_s1 <= mem[rd_idx];
			end
		end

		always_ff @(posedge clk) begin
			if (adv.s2) begin
				prod_s2[e] <= use_s1 ? lbs_pkg::prod_t'(elem_s1 * $signed({1'b0, w_s1})) : '0;
			end
		end
	end

endmodule

// ----- hdl/lbs_merge.sv -----
// Merge stage: adds the lane products per element and rounds to Q16.16.
// Depends on lbs_pkg.
module lbs_merge (
	input  logic              clk,
	input  lbs_pkg::lbs_adv_t adv,
	input  lbs_pkg::prod_t    prod_s2 [lbs_pkg::NumLanes][lbs_pkg::NumElem],
	output lbs_pkg::q16_t     blend_s3 [lbs_pkg::NumElem]
);

	for (genvar e = 0; e < lbs_pkg::NumElem; e++) begin : g_elem
		logic signed [49:0] acc;
		logic signed [49:0] rnd;

		always_comb begin
			acc = 50'sd16384;
			for (int l = 0; l < lbs_pkg::NumLanes; l++) begin
				acc = acc + 50'(prod_s2[l][e]);
			end
			rnd = acc >>> 15;
		end

		always_ff @(posedge clk) begin
			if (adv.s3) begin
				blend_s3[e] <= lbs_pkg::sat_q16(64'(rnd));
			end
		end
	end

endmodule

// ----- hdl/lbs_xform.sv -----
// Transform stages: blended matrix times position (w=1) and normal (w=0),
// with pass-through when the vertex has no pairs. Depends on lbs_pkg.
module lbs_xform (
	input  logic              clk,
	input  lbs_pkg::lbs_adv_t adv,
	input  lbs_pkg::q16_t     blend_s3 [lbs_pkg::NumElem],
	input  lbs_pkg::q16_t     pos_s3 [3],
	input  lbs_pkg::q16_t     nrm_s3 [3],
	input  logic              pass_s3,
	output lbs_pkg::q16_t     res_s5 [6]
);

	lbs_pkg::wide_t pp_s4 [3][3];
	lbs_pkg::wide_t pn_s4 [3][3];
	lbs_pkg::q16_t  pw_s4 [3];
	lbs_pkg::q16_t  pos_s4 [3];
	lbs_pkg::q16_t  nrm_s4 [3];
	logic           pass_s4;
	logic signed [66:0] sp [3];
	logic signed [66:0] sn [3];

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s4[i][j] <= blend_s3[i*4+j] * pos_s3[j];
					pn_s4[i][j] <= blend_s3[i*4+j] * nrm_s3[j];
				end
				pw_s4[i]  <= blend_s3[i*4+3];
				pos_s4[i] <= pos_s3[i];
				nrm_s4[i] <= nrm_s3[i];
			end
			pass_s4 <= pass_s3;
		end
	end

	// Exact Q.32 sums, then round half up and shift down to Q16.16.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sp[i] = 67'(pp_s4[i][0]) + 67'(pp_s4[i][1]) + 67'(pp_s4[i][2])
				+ (67'(pw_s4[i]) <<< 16) + 67'sd32768;
			sn[i] = 67'(pn_s4[i][0]) + 67'(pn_s4[i][1]) + 67'(pn_s4[i][2])
				+ 67'sd32768;
			sp[i] = sp[i] >>> 16;
			sn[i] = sn[i] >>> 16;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			for (int i = 0; i < 3; i++) begin
				res_s5[i]   <= pass_s4 ? pos_s4[i] : lbs_pkg::sat_q16(64'(sp[i]));
				res_s5[3+i] <= pass_s4 ? nrm_s4[i] : lbs_pkg::sat_q16(64'(sn[i]));
			end
		end
	end

endmodule

// ----- hdl/linear_blend_skinning.sv -----
// Linear blend skinning engine, top level. Depends on lbs_pkg, lbs_lane,
// lbs_merge and lbs_xform.
// Vertices pass stages s1 to s5; m_tready low on a full pipeline stalls input.
// Throughput: one transaction per cycle, vertex or palette write, but for stalls;
// each pair lane owns its palette banks, so palette reads never contend.
// Reset clears only the stage valid bits; the palette is undefined until written.
module linear_blend_skinning (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, weight_count, bone_ids_packed,
	// weights_packed, mat_addr, mat_value, zero fill
	input  logic [lbs_pkg::InDataW-1:0]   s_tdata,
	// func
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
	output logic [lbs_pkg::OutDataW-1:0]  m_tdata
);

	lbs_pkg::lbs_adv_t adv;
	logic accept, is_wr, is_vtx;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic [2:0]  weight_count;
	logic [23:0] bone_ids;
	logic [63:0] weights;
	logic [9:0]  mat_addr;
	logic [lbs_pkg::NumLanes-1:0] act;
	logic wr_en;
	lbs_pkg::q16_t pos_in [3];
	lbs_pkg::q16_t nrm_in [3];
	lbs_pkg::q16_t pos_s1 [3], pos_s2 [3], pos_s3 [3];
	lbs_pkg::q16_t nrm_s1 [3], nrm_s2 [3], nrm_s3 [3];
	logic pass_s1, pass_s2, pass_s3;
	lbs_pkg::prod_t prod_s2 [lbs_pkg::NumLanes][lbs_pkg::NumElem];
	lbs_pkg::q16_t  blend_s3 [lbs_pkg::NumElem];
	lbs_pkg::q16_t  res_s5 [6];

	assign weight_count = s_tdata[194:192];
	assign bone_ids     = s_tdata[218:195];
	assign weights      = s_tdata[282:219];
	assign mat_addr     = s_tdata[292:283];
	for (genvar i = 0; i < 3; i++) begin : g_vec
		assign pos_in[i] = s_tdata[32*i +: 32];
		assign nrm_in[i] = s_tdata[96+32*i +: 32];
	end

	// Each stage loads when it is empty or its content moves on.
	assign rdy5 = !vld_s5 || m_tready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign s_tready = rdy1;

	assign accept = s_tvalid && s_tready;
	assign is_wr  = accept && s_tuser[0];
	assign is_vtx = accept && !s_tuser[0];
	assign wr_en  = is_wr && (32'(mat_addr) < lbs_pkg::PalDepth)
		&& (32'(mat_addr[3:0]) < lbs_pkg::NumElem);

	assign adv.s1 = is_vtx;
	assign adv.s2 = vld_s1 && rdy2;
	assign adv.s3 = vld_s2 && rdy3;
	assign adv.s4 = vld_s3 && rdy4;
	assign adv.s5 = vld_s4 && rdy5;

	for (genvar k = 0; k < lbs_pkg::NumLanes; k++) begin : g_lane
		assign act[k] = 32'(weight_count) > k;

		lbs_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.wr_en   (wr_en),
			.wr_elem (mat_addr[3:0]),
			.wr_bone (lbs_pkg::BoneW'(mat_addr[9:4])),
			.wr_data (s_tdata[324:293]),
			.rd_bone (bone_ids[6*k +: 6]),
			.weight  (weights[16*k +: 16]),
			.act     (act[k]),
			.prod_s2 (prod_s2[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= is_vtx;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			pos_s1  <= pos_in;
			nrm_s1  <= nrm_in;
			pass_s1 <= ~|act;
		end
		if (adv.s2) begin
			pos_s2  <= pos_s1;
			nrm_s2  <= nrm_s1;
			pass_s2 <= pass_s1;
		end
		if (adv.s3) begin
			pos_s3  <= pos_s2;
			nrm_s3  <= nrm_s2;
			pass_s3 <= pass_s2;
		end
	end

	lbs_merge u_merge (
		.clk      (clk),
		.adv      (adv),
		.prod_s2  (prod_s2),
		.blend_s3 (blend_s3)
	);

	lbs_xform u_xform (
		.clk      (clk),
		.adv      (adv),
		.blend_s3 (blend_s3),
		.pos_s3   (pos_s3),
		.nrm_s3   (nrm_s3),
		.pass_s3  (pass_s3),
		.res_s5   (res_s5)
	);

	assign m_tvalid = vld_s5;
	assign m_tdata  = {res_s5[5], res_s5[4], res_s5[3], res_s5[2], res_s5[1], res_s5[0]};

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5))
		else $error("input stalled with a bubble in the pipeline");
	a_wr_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0]) |=> !vld_s1)
		else $error("palette write entered the result pipeline");
	a_vtx_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser[0]) |=> vld_s1)
		else $error("vertex transaction lost at the first stage");
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !m_tready) |=> (vld_s5 && $stable(m_tdata)))
		else $error("pending result changed while stalled");

endmodule
